[rtl/core/stack_queue_engine_assert.svh]
// ----------------------------------------------------------------------------
// stack_queue_engine assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef STACK_QUEUE_ENGINE_ASSERT_SVH
`define STACK_QUEUE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SQE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack_queue_engine: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SQE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack_queue_engine: next-cycle check failed");

`endif

[rtl/core/sqe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_pkg
// shared types and constants of the stack / queue engine
// ----------------------------------------------------------------------------
package sqe_pkg;

  localparam int ValueW  = 32;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;
  localparam int RegIdxW  = 1;

  // register index of the mode register
  localparam logic [RegIdxW-1:0] REG_QUEUE_MODE = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_DUMP = 2'd1,
    OP_PEEK = 2'd2,
    OP_POP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_VALUE = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

endpackage

[rtl/core/sqe_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_in_if
// command channel: opcode and push value with valid / ready
// ----------------------------------------------------------------------------
interface sqe_in_if;
  logic                              valid;
  logic                              ready;
  sqe_pkg::op_e                      opcode;
  logic signed [sqe_pkg::ValueW-1:0] push_value;

  modport source (output valid, opcode, push_value, input ready);
  modport sink   (input valid, opcode, push_value, output ready);
endinterface

[rtl/core/sqe_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_out_if
// result channel: status, value and last flag with valid / ready
// ----------------------------------------------------------------------------
interface sqe_out_if;
  logic                              valid;
  logic                              ready;
  sqe_pkg::status_e                  status;
  logic signed [sqe_pkg::ValueW-1:0] out_value;
  logic                              last;

  modport source (output valid, status, out_value, last, input ready);
  modport sink   (input valid, status, out_value, last, output ready);
endinterface

[rtl/core/stack_queue_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine
// bounded store of signed 32-bit values, used as a stack or as a queue
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   in_i      sink       valid / ready  opcode, push_value
//   out_o     source     valid / ready  status, out_value, last
//   apb       slave      psel / penable queue_mode at byte address 0
//
// push and pop are taken without a memory read; a peek holds the command
// side while the single memory read port returns the front entry
// a dump reads one stored element at a time, paced by that read port and
// by the result side; no command is taken until the final element has
// moved from the read stage into the output register
// the command side also waits while a result sits untaken in the output
// register; results are never dropped, a stalled result simply holds
// reset clears the front pointer, count and control; the element memory has no
// clearing pass, since only entries that were pushed are ever read
//
module stack_queue_engine #(
  parameter int DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sqe_in_if.sink                       in_i,
  sqe_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sqe_pkg::ApbAddrW-1:0] paddr,
  input  logic [sqe_pkg::ApbDataW-1:0] pwdata,
  output logic [sqe_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(DEPTH);
  localparam logic [CntW:0]   DepthExt = (CntW + 1)'(DEPTH);

  // mode register
  logic queue_mode;

  sqe_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .queue_mode_o(queue_mode)
  );

  // control state
  sqe_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] dump_ptr_q, dump_ptr_d;
  logic [CntW-1:0] dump_cnt_q, dump_cnt_d;

  // read-pending stage: memory data waiting for the output register
  logic pend_q, pend_d;
  logic pend_last_q, pend_last_d;

  // output register
  logic                              out_valid_q, out_valid_d;
  sqe_pkg::status_e                  out_status_q, out_status_d;
  logic signed [sqe_pkg::ValueW-1:0] out_value_q, out_value_d;
  logic                              out_last_q, out_last_d;

  // element memory, one write and one registered read port
  logic signed [sqe_pkg::ValueW-1:0] mem [DEPTH];
  logic signed [sqe_pkg::ValueW-1:0] rd_data_q;
  logic                              rd_en, wr_en;
  logic [IdxW-1:0]                   rd_addr, wr_addr;

  logic            in_ready, in_fire;
  logic            out_free, pend_free;
  logic [IdxW-1:0] front_inc, front_dec, dump_ptr_inc, back_idx;
  logic [CntW:0]   back_sum, back_wrap;

  // circular index arithmetic, valid for any depth
  assign front_inc    = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign front_dec    = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign dump_ptr_inc = (dump_ptr_q == LastIdx) ? '0 : dump_ptr_q + 1'b1;
  assign back_sum     = (CntW + 1)'(front_q) + (CntW + 1)'(count_q);
  assign back_wrap    = (back_sum >= DepthExt) ? back_sum - DepthExt : back_sum;
  assign back_idx     = back_wrap[IdxW-1:0];

  // output register frees when empty or when its transfer completes now
  assign out_free  = !out_valid_q || out_o.ready;
  assign pend_free = !pend_q || out_free;
  assign in_ready  = (state_q == sqe_pkg::S_IDLE) && !pend_q && out_free;
  assign in_fire   = in_i.valid && in_ready;

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    dump_ptr_d   = dump_ptr_q;
    dump_cnt_d   = dump_cnt_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_addr      = front_q;
    wr_en        = 1'b0;
    wr_addr      = back_idx;

    // result taken by the sink
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // memory data moves into the output register
    if (pend_q && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = sqe_pkg::ST_VALUE;
      out_value_d  = rd_data_q;
      out_last_d   = pend_last_q;
      pend_d       = 1'b0;
    end

    unique case (state_q)
      sqe_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.opcode)
            sqe_pkg::OP_PUSH: begin
              if (count_q == CntFull) begin
                out_valid_d  = 1'b1;
                out_status_d = sqe_pkg::ST_FULL;
                out_value_d  = '0;
                out_last_d   = 1'b1;
              end else begin
                wr_en = 1'b1;
                // stack mode grows the front downwards
                if (!queue_mode) begin
                  front_d = front_dec;
                  wr_addr = front_dec;
                end
                count_d = count_q + 1'b1;
              end
            end
            sqe_pkg::OP_DUMP: begin
              // an empty dump produces no transfer at all
              if (count_q != '0) begin
                state_d    = sqe_pkg::S_DUMP;
                dump_ptr_d = front_q;
                dump_cnt_d = '0;
              end
            end
            sqe_pkg::OP_PEEK: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = sqe_pkg::ST_EMPTY;
                out_value_d  = '0;
                out_last_d   = 1'b1;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = front_q;
                pend_d      = 1'b1;
                pend_last_d = 1'b1;
              end
            end
            sqe_pkg::OP_POP: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = sqe_pkg::ST_EMPTY;
                out_value_d  = '0;
                out_last_d   = 1'b1;
              end else begin
                front_d = front_inc;
                count_d = count_q - 1'b1;
              end
            end
          endcase
        end
      end
      sqe_pkg::S_DUMP: begin
        // one read per cycle whenever the pending stage can take it
        if (pend_free) begin
          rd_en       = 1'b1;
          rd_addr     = dump_ptr_q;
          pend_d      = 1'b1;
          pend_last_d = (dump_cnt_q == count_q - 1'b1);
          dump_ptr_d  = dump_ptr_inc;
          dump_cnt_d  = dump_cnt_q + 1'b1;
          if (dump_cnt_q == count_q - 1'b1) begin
            state_d = sqe_pkg::S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sqe_pkg::S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      dump_cnt_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      dump_cnt_q  <= dump_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dump_ptr_q   <= dump_ptr_d;
    pend_last_q  <= pend_last_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  // element memory; reads and writes never hit the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_i.push_value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;

endmodule

[rtl/core/sqe_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_apb_regs
// apb register block holding the queue mode bit
// ----------------------------------------------------------------------------
module sqe_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sqe_pkg::ApbAddrW-1:0] paddr,
  input  logic [sqe_pkg::ApbDataW-1:0] pwdata,
  output logic [sqe_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output logic                         queue_mode_o
);

  logic                        queue_mode_q, queue_mode_d;
  logic [sqe_pkg::RegIdxW-1:0] reg_idx;
  logic                        wr_fire;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sqe_pkg::ApbAddrW-1:2];
  assign wr_fire = psel && penable && pwrite && pready;

  always_comb begin
    queue_mode_d = queue_mode_q;
    if (wr_fire && (reg_idx == sqe_pkg::REG_QUEUE_MODE)) begin
      queue_mode_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == sqe_pkg::REG_QUEUE_MODE) begin
      prdata = sqe_pkg::ApbDataW'(queue_mode_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mode_q <= 1'b0;
    end else begin
      queue_mode_q <= queue_mode_d;
    end
  end

  assign queue_mode_o = queue_mode_q;

endmodule

[rtl/core/sqe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_checker
// port-level checks of the stack / queue engine, bound to the top level
// ----------------------------------------------------------------------------
`include "stack_queue_engine_assert.svh"

module sqe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input sqe_pkg::op_e                      in_opcode,
  input logic                              out_valid,
  input logic                              out_ready,
  input sqe_pkg::status_e                  out_status,
  input logic signed [sqe_pkg::ValueW-1:0] out_value,
  input logic                              out_last
);

  // a stalled result holds its payload
  `SQE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_value) && $stable(out_last))

  // error results carry a zero value and close the command
  `SQE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid && (out_status != sqe_pkg::ST_VALUE), (out_value == '0) && out_last)

  // no command is taken while a result waits untaken
  `SQE_ASSERT_IMP(a_stall_block, clk_i, rst_ni, out_valid && !out_ready, !in_ready)

  // a peek either answers at once with an error or occupies the read path
  `SQE_ASSERT_NXT(a_peek_busy, clk_i, rst_ni, in_valid && in_ready && (in_opcode == sqe_pkg::OP_PEEK), out_valid || !in_ready)

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_opcode (in_i.opcode),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_status(out_o.status),
  .out_value (out_o.out_value),
  .out_last  (out_o.last)
);
